/* rtl/core/range_bearing_jacobian_defines.svh */
// ----------------------------------------------------------------------------
// range_bearing_jacobian_defines
// Assertion macros shared by the range-bearing Jacobian RTL.
// ----------------------------------------------------------------------------
`ifndef RANGE_BEARING_JACOBIAN_DEFINES_SVH
`define RANGE_BEARING_JACOBIAN_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define RBJ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rbj assertion failed");

// next-cycle implication
`define RBJ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rbj assertion failed");

`endif

/* rtl/core/rbj_pkg.sv */
// ----------------------------------------------------------------------------
// rbj_pkg
// Widths, types and defaults of the range-bearing Jacobian pipeline.
// ----------------------------------------------------------------------------
package rbj_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;   // coordinate and entry width
    localparam int DIFF_W        = 33;   // exact difference / magnitude
    localparam int SQ_W          = 65;   // one square
    localparam int Q_W           = 66;   // sum of squares
    localparam int REM_W         = 67;   // divider partial remainder
    localparam int LANES         = 4;    // divider lanes
    localparam int SKID_DEPTH    = 2;

    // divider lane assignment
    localparam int LANE_SX = 0;
    localparam int LANE_SY = 1;
    localparam int LANE_AY = 2;
    localparam int LANE_AX = 3;

    typedef struct packed {
        logic dx_pos;
        logic dy_pos;
        logic dy_neg;
        logic degen;
    } t_side;

    typedef struct packed {
        logic [DATA_W-1:0] range_dx;
        logic [DATA_W-1:0] range_dy;
        logic [DATA_W-1:0] bearing_dx;
        logic [DATA_W-1:0] bearing_dy;
        logic              degen;
        logic              sat;
    } t_result;

endpackage

/* rtl/core/rbj_front.sv */
// ----------------------------------------------------------------------------
// rbj_front
// Differences, magnitudes, squares and sum of squares (three stages).
// ----------------------------------------------------------------------------
module rbj_front (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_en,
    input  logic                                            i_valid,
    input  logic [rbj_pkg::DATA_W-1:0]                      i_landmark_x,
    input  logic [rbj_pkg::DATA_W-1:0]                      i_landmark_y,
    input  logic [rbj_pkg::DATA_W-1:0]                      i_robot_x,
    input  logic [rbj_pkg::DATA_W-1:0]                      i_robot_y,
    output logic                                            o_valid,
    output logic [rbj_pkg::Q_W-1:0]                         o_q,
    output logic [rbj_pkg::LANES-1:0][rbj_pkg::REM_W-1:0]   o_num,
    output rbj_pkg::t_side                                  o_side
);

    localparam int DW = rbj_pkg::DIFF_W;

    logic [2:0]           r_valid;
    logic [DW-1:0]        r_ax1, r_ay1, r_ax2, r_ay2;
    rbj_pkg::t_side       r_side1, r_side2, r_side3;
    logic [rbj_pkg::SQ_W-1:0] r_sx2, r_sy2;
    logic [rbj_pkg::Q_W-1:0]  r_q3;
    logic [rbj_pkg::LANES-1:0][rbj_pkg::REM_W-1:0] r_num3;

    logic [DW-1:0]        n_dx, n_dy, n_ax, n_ay;
    rbj_pkg::t_side       n_side;
    logic [2*DW-1:0]      n_px, n_py;

    always_comb begin
        n_dx = {i_landmark_x[rbj_pkg::DATA_W-1], i_landmark_x}
             - {i_robot_x[rbj_pkg::DATA_W-1], i_robot_x};
        n_dy = {i_landmark_y[rbj_pkg::DATA_W-1], i_landmark_y}
             - {i_robot_y[rbj_pkg::DATA_W-1], i_robot_y};
        n_ax = n_dx[DW-1] ? (~n_dx + DW'(1)) : n_dx;
        n_ay = n_dy[DW-1] ? (~n_dy + DW'(1)) : n_dy;
        n_side.dx_pos = !n_dx[DW-1] && (n_dx != '0);
        n_side.dy_pos = !n_dy[DW-1] && (n_dy != '0);
        n_side.dy_neg = n_dy[DW-1];
        n_side.degen  = (n_dx == '0) && (n_dy == '0);
        n_px = {{DW{1'b0}}, r_ax1} * {{DW{1'b0}}, r_ax1};
        n_py = {{DW{1'b0}}, r_ay1} * {{DW{1'b0}}, r_ay1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax1   <= n_ax;
            r_ay1   <= n_ay;
            r_side1 <= n_side;
            r_sx2   <= n_px[rbj_pkg::SQ_W-1:0];
            r_sy2   <= n_py[rbj_pkg::SQ_W-1:0];
            r_ax2   <= r_ax1;
            r_ay2   <= r_ay1;
            r_side2 <= r_side1;
            r_q3    <= {1'b0, r_sx2} + {1'b0, r_sy2};
            r_num3[rbj_pkg::LANE_SX] <= rbj_pkg::REM_W'(r_sx2);
            r_num3[rbj_pkg::LANE_SY] <= rbj_pkg::REM_W'(r_sy2);
            r_num3[rbj_pkg::LANE_AY] <= rbj_pkg::REM_W'(r_ay2);
            r_num3[rbj_pkg::LANE_AX] <= rbj_pkg::REM_W'(r_ax2);
            r_side3 <= r_side2;
        end
    end

    assign o_valid = r_valid[2];
    assign o_q     = r_q3;
    assign o_num   = r_num3;
    assign o_side  = r_side3;

endmodule

/* rtl/core/rbj_div_pipe.sv */
// ----------------------------------------------------------------------------
// rbj_div_pipe
// Four restoring dividers, one quotient bit per stage: floor(n * 2^2F / q),
// valid for n <= q.
// ----------------------------------------------------------------------------
module rbj_div_pipe #(
    parameter int FRAC_BITS = rbj_pkg::FRAC_BITS_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_en,
    input  logic                                            i_valid,
    input  logic [rbj_pkg::Q_W-1:0]                         i_q,
    input  logic [rbj_pkg::LANES-1:0][rbj_pkg::REM_W-1:0]   i_num,
    input  rbj_pkg::t_side                                  i_side,
    output logic                                            o_valid,
    output logic [rbj_pkg::LANES-1:0][2*FRAC_BITS:0]        o_quo,
    output rbj_pkg::t_side                                  o_side
);

    localparam int NSTEP = 2 * FRAC_BITS + 1;
    localparam int QW    = NSTEP;
    localparam int RW    = rbj_pkg::REM_W;
    localparam int NL    = rbj_pkg::LANES;

    logic [NSTEP-1:0]                 r_valid;
    logic [NL-1:0][RW-1:0]            r_rem  [NSTEP];
    logic [NL-1:0][QW-1:0]            r_quo  [NSTEP];
    logic [rbj_pkg::Q_W-1:0]          r_qd   [NSTEP];
    rbj_pkg::t_side                   r_side [NSTEP];

    for (genvar k = 0; k < NSTEP; k++) begin : g_stage
        logic [NL-1:0][RW-1:0]   rem_in, n_rem;
        logic [NL-1:0][QW-1:0]   quo_in, n_quo;
        logic [rbj_pkg::Q_W-1:0] qd_in;
        rbj_pkg::t_side          side_in;
        logic                    val_in;

        if (k == 0) begin : g_first
            assign rem_in  = i_num;
            assign quo_in  = '0;
            assign qd_in   = i_q;
            assign side_in = i_side;
            assign val_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign quo_in  = r_quo[k-1];
            assign qd_in   = r_qd[k-1];
            assign side_in = r_side[k-1];
            assign val_in  = r_valid[k-1];
        end

        for (genvar l = 0; l < NL; l++) begin : g_lane
            logic [RW-1:0] trial;
            logic          ge;
            always_comb begin
                // first step compares n itself: quotient bit 2F is set only when n == q
                trial = (k == 0) ? rem_in[l] : {rem_in[l][RW-2:0], 1'b0};
                ge    = trial >= {1'b0, qd_in};
                n_rem[l] = ge ? (trial - {1'b0, qd_in}) : trial;
                n_quo[l] = {quo_in[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= val_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_quo[k]  <= n_quo;
                r_qd[k]   <= qd_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[NSTEP-1];
    assign o_quo   = r_quo[NSTEP-1];
    assign o_side  = r_side[NSTEP-1];

endmodule

/* rtl/core/rbj_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// rbj_sqrt_pipe
// Two digit-by-digit integer square roots, one root bit per stage; the
// bearing quotients ride alongside.
// ----------------------------------------------------------------------------
module rbj_sqrt_pipe #(
    parameter int FRAC_BITS = rbj_pkg::FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  logic                                        i_valid,
    input  logic [rbj_pkg::LANES-1:0][2*FRAC_BITS:0]    i_quo,
    input  rbj_pkg::t_side                              i_side,
    output logic                                        o_valid,
    output logic [1:0][FRAC_BITS:0]                     o_root,
    output logic [1:0][2*FRAC_BITS:0]                   o_bq,
    output rbj_pkg::t_side                              o_side
);

    localparam int SSTEP = FRAC_BITS + 1;
    localparam int SW    = SSTEP;
    localparam int XW    = 2 * SSTEP;
    localparam int RW    = FRAC_BITS + 4;
    localparam int QW    = 2 * FRAC_BITS + 1;

    logic [SSTEP-1:0]        r_valid;
    logic [1:0][XW-1:0]      r_rad  [SSTEP];
    logic [1:0][RW-1:0]      r_rem  [SSTEP];
    logic [1:0][SW-1:0]      r_root [SSTEP];
    logic [1:0][QW-1:0]      r_bq   [SSTEP];
    rbj_pkg::t_side          r_side [SSTEP];

    for (genvar k = 0; k < SSTEP; k++) begin : g_stage
        localparam int DIG = FRAC_BITS - k;
        logic [1:0][XW-1:0] rad_in;
        logic [1:0][RW-1:0] rem_in, n_rem;
        logic [1:0][SW-1:0] root_in, n_root;
        logic [1:0][QW-1:0] bq_in;
        rbj_pkg::t_side     side_in;
        logic               val_in;

        if (k == 0) begin : g_first
            assign rad_in[0] = XW'(i_quo[rbj_pkg::LANE_SX]);
            assign rad_in[1] = XW'(i_quo[rbj_pkg::LANE_SY]);
            assign bq_in[0]  = i_quo[rbj_pkg::LANE_AY];
            assign bq_in[1]  = i_quo[rbj_pkg::LANE_AX];
            assign rem_in    = '0;
            assign root_in   = '0;
            assign side_in   = i_side;
            assign val_in    = i_valid;
        end else begin : g_next
            assign rad_in  = r_rad[k-1];
            assign bq_in   = r_bq[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
            assign val_in  = r_valid[k-1];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [RW-1:0] acc, trial;
            logic          ge;
            always_comb begin
                acc   = {rem_in[l][RW-3:0], rad_in[l][2*DIG+1 -: 2]};
                trial = RW'({root_in[l], 2'b01});
                ge    = acc >= trial;
                n_rem[l]  = ge ? (acc - trial) : acc;
                n_root[l] = {root_in[l][SW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= val_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= rad_in;
                r_bq[k]   <= bq_in;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[SSTEP-1];
    assign o_root  = r_root[SSTEP-1];
    assign o_bq    = r_bq[SSTEP-1];
    assign o_side  = r_side[SSTEP-1];

endmodule

/* rtl/core/rbj_out.sv */
// ----------------------------------------------------------------------------
// rbj_out
// Sign, saturation and degenerate forcing, then a two-entry output skid.
// ----------------------------------------------------------------------------
module rbj_out #(
    parameter int FRAC_BITS = rbj_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [1:0][FRAC_BITS:0]         i_root,
    input  logic [1:0][2*FRAC_BITS:0]       i_bq,
    input  rbj_pkg::t_side                  i_side,
    input  logic                            i_ready,
    output logic                            o_en,
    output logic                            o_valid,
    output rbj_pkg::t_result                o_result
);

    localparam int DW = rbj_pkg::DATA_W;
    localparam int CW = $clog2(rbj_pkg::SKID_DEPTH + 1);

    logic [CW-1:0]      r_count, n_count;
    rbj_pkg::t_result   r_slot0, r_slot1, n_slot0, n_slot1, res;
    logic               push, pop;
    logic [DW:0]        bdx, bdy;

    // {clipped, value} of a signed entry with magnitude mag
    function automatic logic [DW:0] sat_entry(input logic neg, input logic [63:0] mag);
        logic [DW:0] r;
        if (!neg) begin
            r = (mag > 64'h7FFF_FFFF) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, mag[DW-1:0]};
        end else begin
            r = (mag > 64'h8000_0000) ? {1'b1, 32'h8000_0000}
                                      : {1'b0, DW'(32'd0 - mag[DW-1:0])};
        end
        return r;
    endfunction

    always_comb begin
        bdx = sat_entry(i_side.dy_neg, 64'(i_bq[0]));
        bdy = sat_entry(i_side.dx_pos, 64'(i_bq[1]));
        res.range_dx   = i_side.dx_pos ? (32'd0 - DW'(i_root[0])) : DW'(i_root[0]);
        res.range_dy   = i_side.dy_pos ? (32'd0 - DW'(i_root[1])) : DW'(i_root[1]);
        res.bearing_dx = bdx[DW-1:0];
        res.bearing_dy = bdy[DW-1:0];
        res.degen      = 1'b0;
        res.sat        = bdx[DW] | bdy[DW];
        if (i_side.degen) begin
            res = '0;
            res.degen = 1'b1;
        end
    end

    assign o_en    = (r_count != CW'(rbj_pkg::SKID_DEPTH));
    assign push    = i_valid && o_en;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_count = r_count;
        case ({push, pop})
            2'b10: begin
                if (r_count == '0) n_slot0 = res;
                else               n_slot1 = res;
                n_count = r_count + CW'(1);
            end
            2'b01: begin
                n_slot0 = r_slot1;
                n_count = r_count - CW'(1);
            end
            2'b11: begin
                if (r_count == CW'(1)) begin
                    n_slot0 = res;
                end else begin
                    n_slot0 = r_slot1;
                    n_slot1 = res;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_result = r_slot0;

endmodule

/* rtl/core/range_bearing_jacobian.sv */
// ----------------------------------------------------------------------------
// range_bearing_jacobian
// Range-bearing measurement Jacobian entries from robot and landmark position.
// ----------------------------------------------------------------------------
//  channel  | valid    | ready    | payload
//  ---------+----------+----------+---------------------------------------------
//  in       | i_valid  | o_ready  | i_landmark_x/y, i_robot_x/y (signed Q.F)
//  out      | o_valid  | i_ready  | o_range_dx/dy_entry, o_bearing_dx/dy_entry,
//           |          |          | o_degenerate, o_saturated
//
//  One beat per cycle while i_ready stays high. Pipeline stages in order:
//  3 front stages, 2F+1 divider stages (one quotient bit each), F+1 square
//  root stages (one root bit each), one output register.
//  Reset (i_rst_n low, synchronous) clears all valid bits and the skid count.
//  The pipeline freezes only when both output skid entries are full; o_ready
//  decodes the registered skid count, high while at most one result waits downstream.
// ----------------------------------------------------------------------------
`include "range_bearing_jacobian_defines.svh"

module range_bearing_jacobian #(
    parameter int FRAC_BITS = rbj_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rbj_pkg::DATA_W-1:0]  i_landmark_x,
    input  logic [rbj_pkg::DATA_W-1:0]  i_landmark_y,
    input  logic [rbj_pkg::DATA_W-1:0]  i_robot_x,
    input  logic [rbj_pkg::DATA_W-1:0]  i_robot_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rbj_pkg::DATA_W-1:0]  o_range_dx_entry,
    output logic [rbj_pkg::DATA_W-1:0]  o_range_dy_entry,
    output logic [rbj_pkg::DATA_W-1:0]  o_bearing_dx_entry,
    output logic [rbj_pkg::DATA_W-1:0]  o_bearing_dy_entry,
    output logic                        o_degenerate,
    output logic                        o_saturated
);

    localparam int RANGE_MAX = 2 ** FRAC_BITS;

    // global advance: every stage before the skid moves together unless the skid is full
    logic en;

    logic                                               fr_valid;
    logic [rbj_pkg::Q_W-1:0]                            fr_q;
    logic [rbj_pkg::LANES-1:0][rbj_pkg::REM_W-1:0]      fr_num;
    rbj_pkg::t_side                                     fr_side;

    logic                                               dv_valid;
    logic [rbj_pkg::LANES-1:0][2*FRAC_BITS:0]           dv_quo;
    rbj_pkg::t_side                                     dv_side;

    logic                                               sq_valid;
    logic [1:0][FRAC_BITS:0]                            sq_root;
    logic [1:0][2*FRAC_BITS:0]                          sq_bq;
    rbj_pkg::t_side                                     sq_side;

    rbj_pkg::t_result                                   result;

    // dx, dy, |dx|, |dy|, squares, q
    rbj_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_valid),
        .i_landmark_x (i_landmark_x),
        .i_landmark_y (i_landmark_y),
        .i_robot_x    (i_robot_x),
        .i_robot_y    (i_robot_y),
        .o_valid      (fr_valid),
        .o_q          (fr_q),
        .o_num        (fr_num),
        .o_side       (fr_side)
    );

    // dx^2/q, dy^2/q (for the range roots), |dy|/q, |dx|/q, all scaled 2^2F
    rbj_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_q     (fr_q),
        .i_num   (fr_num),
        .i_side  (fr_side),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // |d| * 2^F / sqrt(q) by isqrt of the scaled ratio
    rbj_sqrt_pipe #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_valid),
        .i_quo   (dv_quo),
        .i_side  (dv_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_bq    (sq_bq),
        .o_side  (sq_side)
    );

    // signs, clipping of bearing entries, coincident-point forcing, skid
    rbj_out #(.FRAC_BITS(FRAC_BITS)) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sq_valid),
        .i_root   (sq_root),
        .i_bq     (sq_bq),
        .i_side   (sq_side),
        .i_ready  (i_ready),
        .o_en     (en),
        .o_valid  (o_valid),
        .o_result (result)
    );

    assign o_ready            = en;
    assign o_range_dx_entry   = result.range_dx;
    assign o_range_dy_entry   = result.range_dy;
    assign o_bearing_dx_entry = result.bearing_dx;
    assign o_bearing_dy_entry = result.bearing_dy;
    assign o_degenerate       = result.degen;
    assign o_saturated        = result.sat;

    // coincident points: all entries zero, no clipping
    `RBJ_ASSERT_IMP(a_degen_zero, o_valid && o_degenerate,
        (o_range_dx_entry == '0) && (o_range_dy_entry == '0) &&
        (o_bearing_dx_entry == '0) && (o_bearing_dy_entry == '0) && !o_saturated)
    // range entries never exceed one in magnitude
    `RBJ_ASSERT_IMP(a_range_mag, o_valid,
        ($signed(o_range_dx_entry) <= RANGE_MAX) && ($signed(o_range_dx_entry) >= -RANGE_MAX) &&
        ($signed(o_range_dy_entry) <= RANGE_MAX) && ($signed(o_range_dy_entry) >= -RANGE_MAX))
    // an empty skid always takes input
    `RBJ_ASSERT_IMP(a_empty_ready, !o_valid, o_ready)
    // input held off only with results pending
    `RBJ_ASSERT_NXT(a_stall_pending, !o_ready, o_valid)

endmodule

/* sim/range_bearing_jacobian_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_bearing_jacobian_tb
// Self-checking bench for the range-bearing Jacobian pipeline.
// ----------------------------------------------------------------------------
// Directed corners come first: coincident points, extreme coordinates, and
// LSB-sized offsets that clip the bearing entries or land on the most negative entry.
// Random landmark queries follow, mixing full-range points, near points and
// coincident points. Both channels idle in random bursts. At one point the
// result side holds off long enough to back the pipe up and stall the input.
// Every result is checked field by field against a behavioral prediction.
// ----------------------------------------------------------------------------
module range_bearing_jacobian_tb;

    localparam int N_ITEMS   = 1100;
    localparam int QUIET_AT  = 950;     // no idling from this beat on
    localparam int HOLD_AT   = 300;     // long result-side hold-off here
    localparam int HOLD_LEN  = 400;
    localparam int LATENCY   = 3 * rbj_pkg::FRAC_BITS_DEF + 6;
    localparam int CYC_LIMIT = 300000;
    localparam int TWO_F     = 2 * rbj_pkg::FRAC_BITS_DEF;

    // ------------------------------------------------------------------------
    // Jacobian predictor and expected-result queue
    // ------------------------------------------------------------------------
    class jacobian_scoreboard;
        rbj_pkg::t_result pending[$];
        int               n_bad;
        int               n_degen;
        int               n_sat;
        int               n_checked;

        function automatic logic [63:0] root64(logic [63:0] x);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x   = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // signed clip of a bearing magnitude to 32 bits
        function automatic logic [31:0] clip(logic neg, logic [127:0] mag,
                                             ref logic sat);
            if (!neg) begin
                if (mag > 128'h7FFF_FFFF) begin
                    sat = 1'b1;
                    return 32'h7FFF_FFFF;
                end
                return mag[31:0];
            end
            if (mag > 128'h8000_0000) begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return -mag[31:0];
        endfunction

        function void note_query(logic [31:0] lx, logic [31:0] ly,
                                 logic [31:0] rx, logic [31:0] ry);
            logic signed [32:0] dx;
            logic signed [32:0] dy;
            logic [127:0]       ax, ay, sx, sy, q;
            logic [63:0]        rtx, rty;
            logic               sat;
            rbj_pkg::t_result   e;
            dx  = $signed({lx[31], lx}) - $signed({rx[31], rx});
            dy  = $signed({ly[31], ly}) - $signed({ry[31], ry});
            e   = '0;
            sat = 1'b0;
            if (dx == 0 && dy == 0) begin
                e.degen = 1'b1;
            end else begin
                ax  = {95'd0, (dx < 0) ? -dx : dx};
                ay  = {95'd0, (dy < 0) ? -dy : dy};
                sx  = ax * ax;
                sy  = ay * ay;
                q   = sx + sy;
                rtx = root64(64'((sx << TWO_F) / q));
                rty = root64(64'((sy << TWO_F) / q));
                e.range_dx   = (dx > 0) ? -rtx[31:0] : rtx[31:0];
                e.range_dy   = (dy > 0) ? -rty[31:0] : rty[31:0];
                e.bearing_dx = clip(dy < 0, (ay << TWO_F) / q, sat);
                e.bearing_dy = clip(dx > 0, (ax << TWO_F) / q, sat);
                e.sat        = sat;
            end
            pending.push_back(e);
        endfunction

        function void check_result(rbj_pkg::t_result got);
            rbj_pkg::t_result e;
            n_checked++;
            if (got.degen) n_degen++;
            if (got.sat) n_sat++;
            if (pending.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("ERROR: result beat with nothing pending");
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("ERROR: beat %0d mismatch", n_checked);
                    $display("  exp rdx=%h rdy=%h bdx=%h bdy=%h deg=%b sat=%b",
                             e.range_dx, e.range_dy, e.bearing_dx, e.bearing_dy,
                             e.degen, e.sat);
                    $display("  got rdx=%h rdy=%h bdx=%h bdy=%h deg=%b sat=%b",
                             got.range_dx, got.range_dy, got.bearing_dx,
                             got.bearing_dy, got.degen, got.sat);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_landmark_x, i_landmark_y, i_robot_x, i_robot_y;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_range_dx_entry, o_range_dy_entry;
    logic [31:0] o_bearing_dx_entry, o_bearing_dy_entry;
    logic        o_degenerate, o_saturated;

    jacobian_scoreboard sb;
    int                 n_accepted;
    int                 cyc;

    range_bearing_jacobian u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_landmark_x       (i_landmark_x),
        .i_landmark_y       (i_landmark_y),
        .i_robot_x          (i_robot_x),
        .i_robot_y          (i_robot_y),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_range_dx_entry   (o_range_dx_entry),
        .o_range_dy_entry   (o_range_dy_entry),
        .o_bearing_dx_entry (o_bearing_dx_entry),
        .o_bearing_dy_entry (o_bearing_dy_entry),
        .o_degenerate       (o_degenerate),
        .o_saturated        (o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= CYC_LIMIT) begin
                $display("Timeout after %0d cycles", cyc);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // present one query beat and hold it until accepted
    task automatic send_query(logic [31:0] lx, logic [31:0] ly,
                              logic [31:0] rx, logic [31:0] ry);
        int gap;
        if (n_accepted < QUIET_AT && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_landmark_x <= lx;
        i_landmark_y <= ly;
        i_robot_x    <= rx;
        i_robot_y    <= ry;
        do @(posedge i_clk); while (!o_ready);
        sb.note_query(lx, ly, rx, ry);
        n_accepted++;
    endtask

    // random coordinate with a mix of far, near and coincident points
    task automatic send_random();
        logic [31:0] lx, ly, rx, ry;
        int          kind;
        kind = $urandom_range(0, 9);
        lx   = $urandom;
        ly   = $urandom;
        rx   = $urandom;
        ry   = $urandom;
        case (kind) inside
            0: begin
                rx = lx;
                ry = ly;
            end
            [1:3]: begin
                // near: small offsets give large bearing entries
                rx = lx + $urandom_range(0, 8) - 4;
                ry = ly + $urandom_range(0, 8) - 4;
            end
            [4:5]: begin
                rx = lx + ($urandom_range(0, 32'h3FFFF) - 32'h20000);
                ry = ly + ($urandom_range(0, 32'h3FFFF) - 32'h20000);
            end
            6: ry = ly;
            default: ;
        endcase
        send_query(lx, ly, rx, ry);
    endtask

    // result side: random idle bursts plus one long hold-off
    initial begin
        int  burst;
        bit  held;
        logic rdy;
        burst   = 0;
        held    = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && n_accepted >= HOLD_AT) begin
                held  = 1;
                burst = HOLD_LEN;
            end
            if (burst > 0) begin
                burst--;
                rdy = 1'b0;
            end else if (n_accepted < QUIET_AT && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 11) - 1;
                rdy   = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            i_ready <= rdy;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        rbj_pkg::t_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.range_dx   = o_range_dx_entry;
            got.range_dy   = o_range_dy_entry;
            got.bearing_dx = o_bearing_dx_entry;
            got.bearing_dy = o_bearing_dy_entry;
            got.degen      = o_degenerate;
            got.sat        = o_saturated;
            sb.check_result(got);
        end
    end

    initial begin
        sb           = new();
        n_accepted   = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_landmark_x = '0;
        i_landmark_y = '0;
        i_robot_x    = '0;
        i_robot_y    = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // coincident points
        send_query(32'h0, 32'h0, 32'h0, 32'h0);
        send_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        // widest offsets in each direction
        send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_query(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_query(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
        send_query(32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
        // one-LSB offsets clip the bearing entries
        send_query(32'h1, 32'h0, 32'h0, 32'h0);
        send_query(32'h0, 32'h1, 32'h0, 32'h0);
        send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        // two-LSB offsets: exactly on the negative edge, clipped on the positive side
        send_query(32'h2, 32'h0, 32'h0, 32'h0);
        send_query(32'h0, 32'hFFFF_FFFE, 32'h0, 32'h0);
        send_query(32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0);
        send_query(32'h0, 32'h2, 32'h0, 32'h0);
        // unit-step, larger and LSB-sized offsets in Q16.16, all four quadrants
        send_query(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_query(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
        send_query(32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0);
        send_query(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        send_query(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);

        while (n_accepted < N_ITEMS) send_random();
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Checked %0d result beats from %0d queries (%0d coincident, %0d clipped).",
                 sb.n_checked, n_accepted, sb.n_degen, sb.n_sat);
        $display("Mismatches: %0d", sb.n_bad);
        if (sb.n_bad == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
